FILE: rtl/ttt_pkg.sv
package ttt_pkg;

   localparam int unsigned MaxEntriesDefault = 64;
   localparam int unsigned TableLimit = 64;

   typedef enum logic [3:0] {
      REQ_ADD       = 4'd0,
      REQ_REMOVE    = 4'd1,
      REQ_CLEAR     = 4'd2,
      REQ_ROTATE    = 4'd3,
      REQ_MIRROR_X  = 4'd4,
      REQ_MIRROR_Y  = 4'd5,
      REQ_NORMALIZE = 4'd6,
      REQ_READ      = 4'd7,
      REQ_EXTENTS   = 4'd8,
      REQ_PLACE     = 4'd9
   } req_code_type;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_INDEX = 2'd2;
   localparam logic [1:0] STATUS_EMPTY = 2'd3;

   localparam logic [1:0] DIR_NORTH = 2'd0;
   localparam logic [1:0] DIR_EAST  = 2'd1;
   localparam logic [1:0] DIR_SOUTH = 2'd2;
   localparam logic [1:0] DIR_WEST  = 2'd3;

   typedef struct packed {
      logic [3:0]  req_type;
      logic signed [15:0] rel_x;
      logic signed [15:0] rel_y;
      logic [15:0] kind_code;
      logic [1:0]  direction;
      logic [31:0] metadata;
      logic [5:0]  index;
      logic [1:0]  rotation;
      logic signed [31:0] anchor_x;
      logic signed [31:0] anchor_y;
   } req_type_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [6:0]  entry_index;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic [15:0] out_type;
      logic [1:0]  out_direction;
      logic [31:0] out_metadata;
      logic signed [15:0] min_x;
      logic signed [15:0] min_y;
      logic signed [15:0] max_x;
      logic signed [15:0] max_y;
      logic        last;
   } rsp_type_type;

   // Datapath operations driven by the controller.
   typedef enum logic [2:0] {
      OP_IDLE,
      OP_WRITE_NEW,
      OP_EXT_CLEAR,
      OP_READ,
      OP_SCAN,
      OP_REWRITE,
      OP_SHIFT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [5:0] addr;
      logic       first;
      logic       fetch_valid;
   } dp_cmd_type;

   typedef struct packed {
      logic [6:0] count;
   } dp_status_type;

endpackage

FILE: rtl/ttt_if.sv
interface ttt_req_if import ttt_pkg::*; ();
   logic          valid;
   logic          ready;
   req_type_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ttt_rsp_if import ttt_pkg::*; ();
   logic          valid;
   logic          ready;
   rsp_type_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/ttt_datapath.sv
module ttt_datapath import ttt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   input  req_type_type  req,
   output dp_status_type stat,
   output logic [31:0]   rd_pos,
   output logic [15:0]   rd_type,
   output logic [1:0]    rd_dir,
   output logic [31:0]   rd_meta,
   output logic signed [15:0] mnx_ff,
   output logic signed [15:0] mny_ff,
   output logic signed [15:0] mxx_ff,
   output logic signed [15:0] mxy_ff,
   input  logic          count_inc,
   input  logic          count_dec,
   input  logic          count_clr
);

   logic [31:0] pos_mem  [TableLimit];
   logic [15:0] type_mem [TableLimit];
   logic [1:0]  dir_mem  [TableLimit];
   logic [31:0] meta_mem [TableLimit];
   logic [6:0]  count_ff;
   logic [5:0]  wr_addr_ff;

   logic signed [15:0] cx, cy;
   logic [15:0] w, h, x, y, nx, ny;
   logic [1:0]  nd;

   assign stat.count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (count_clr) count_ff <= '0;
      else if (count_inc) count_ff <= count_ff + 7'd1;
      else if (count_dec) count_ff <= count_ff - 7'd1;
   end

   // Registered read port; the controller consumes the data in the cycle after it presents the address.
   always_ff @(posedge clock) begin
      rd_pos  <= pos_mem[cmd.addr];
      rd_type <= type_mem[cmd.addr];
      rd_dir  <= dir_mem[cmd.addr];
      rd_meta <= meta_mem[cmd.addr];
      wr_addr_ff <= cmd.addr;
   end

   assign cx = signed'(rd_pos[15:0]);
   assign cy = signed'(rd_pos[31:16]);
   assign w = mxx_ff - mnx_ff;
   assign h = mxy_ff - mny_ff;
   assign x = rd_pos[15:0] - mnx_ff;
   assign y = rd_pos[31:16] - mny_ff;

   always_comb begin
      nx = x;
      ny = y;
      nd = rd_dir;
      unique case (req_code_type'(req.req_type))
         REQ_ROTATE: begin
            unique case (req.rotation)
               2'd1:    begin nx = h - y; ny = x; end
               2'd2:    begin nx = w - x; ny = h - y; end
               default: begin nx = y; ny = w - x; end
            endcase
            nd = rd_dir + req.rotation;
         end
         REQ_MIRROR_X: begin
            nx = w - x;
            ny = rd_pos[31:16];
            if (rd_dir == DIR_EAST) nd = DIR_WEST;
            else if (rd_dir == DIR_WEST) nd = DIR_EAST;
         end
         REQ_MIRROR_Y: begin
            nx = rd_pos[15:0];
            ny = h - y;
            if (rd_dir == DIR_NORTH) nd = DIR_SOUTH;
            else if (rd_dir == DIR_SOUTH) nd = DIR_NORTH;
         end
         default: begin end
      endcase
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_WRITE_NEW: begin
            pos_mem[count_ff[5:0]]  <= {req.rel_y, req.rel_x};
            type_mem[count_ff[5:0]] <= req.kind_code;
            dir_mem[count_ff[5:0]]  <= req.direction;
            meta_mem[count_ff[5:0]] <= req.metadata;
         end
         OP_REWRITE: if (cmd.fetch_valid) begin
            pos_mem[wr_addr_ff] <= {ny, nx};
            dir_mem[wr_addr_ff] <= nd;
         end
         OP_SHIFT: if (cmd.fetch_valid) begin
            pos_mem[wr_addr_ff - 6'd1]  <= rd_pos;
            type_mem[wr_addr_ff - 6'd1] <= rd_type;
            dir_mem[wr_addr_ff - 6'd1]  <= rd_dir;
            meta_mem[wr_addr_ff - 6'd1] <= rd_meta;
         end
         default: begin end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EXT_CLEAR) begin
         mnx_ff <= '0; mny_ff <= '0; mxx_ff <= '0; mxy_ff <= '0;
      end else if (cmd.op == OP_SCAN && cmd.fetch_valid) begin
         if (cmd.first || cx < mnx_ff) mnx_ff <= cx;
         if (cmd.first || cy < mny_ff) mny_ff <= cy;
         if (cmd.first || cx > mxx_ff) mxx_ff <= cx;
         if (cmd.first || cy > mxy_ff) mxy_ff <= cy;
      end
   end

endmodule

FILE: rtl/ttt_controller.sv
module ttt_controller import ttt_pkg::*; #(
   parameter int unsigned ENTRY_CAP = TableLimit
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type_type  req_in,
   output req_type_type  req_ff,
   input  dp_status_type stat,
   output dp_cmd_type    cmd,
   output logic          count_inc,
   output logic          count_dec,
   output logic          count_clr,
   input  logic [31:0]   rd_pos,
   input  logic [15:0]   rd_type,
   input  logic [1:0]    rd_dir,
   input  logic [31:0]   rd_meta,
   input  logic signed [15:0] mnx,
   input  logic signed [15:0] mny,
   input  logic signed [15:0] mxx,
   input  logic signed [15:0] mxy,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type_type  rsp_ff
);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_SCAN, S_REWRITE, S_SHIFT, S_READ, S_PLACE, S_EXT, S_SEND
   } state_type;

   state_type    state_ff;
   state_type    dec_state;
   logic [6:0]   addr_ff;
   logic [6:0]   dec_addr;
   logic         fv_ff;
   logic         valid_ff;
   rsp_type_type rsp_in;
   logic [6:0]   count;
   logic [5:0]   last_idx;
   logic         full;
   logic         index_bad;

   assign count = stat.count;
   assign last_idx = 6'(count - 7'd1);
   assign full = (count >= 7'(ENTRY_CAP));
   assign index_bad = ({1'b0, req_ff.index} >= count);
   // A new request is taken only once the previous result has been transferred.
   assign req_ready = (state_ff == S_IDLE) && !valid_ff;
   assign rsp_valid = valid_ff;

   always_comb begin
      cmd.op = OP_IDLE;
      cmd.addr = addr_ff[5:0];
      cmd.first = (addr_ff == 7'd1);
      cmd.fetch_valid = fv_ff;
      count_inc = 1'b0;
      count_dec = 1'b0;
      count_clr = 1'b0;
      rsp_in = rsp_ff;
      dec_state = S_SEND;
      dec_addr = '0;
      unique case (state_ff)
         S_DECODE: begin
            rsp_in = '0;
            rsp_in.last = 1'b1;
            unique case (req_code_type'(req_ff.req_type))
               REQ_ADD: begin
                  if (full) rsp_in.status = STATUS_FULL;
                  else begin
                     rsp_in.entry_index = count;
                     cmd.op = OP_WRITE_NEW;
                     count_inc = 1'b1;
                  end
               end
               REQ_REMOVE: begin
                  if (index_bad) rsp_in.status = STATUS_INDEX;
                  else begin
                     rsp_in.entry_index = {1'b0, req_ff.index};
                     dec_addr = {1'b0, req_ff.index} + 7'd1;
                     dec_state = S_SHIFT;
                  end
               end
               REQ_CLEAR: count_clr = 1'b1;
               REQ_ROTATE, REQ_MIRROR_X, REQ_MIRROR_Y, REQ_NORMALIZE: begin
                  if (count == 7'd0) rsp_in.status = STATUS_EMPTY;
                  else if (!(req_ff.req_type == REQ_ROTATE && req_ff.rotation == 2'd0))
                     dec_state = S_SCAN;
               end
               REQ_READ: begin
                  if (index_bad) rsp_in.status = STATUS_INDEX;
                  else begin
                     dec_addr = {1'b0, req_ff.index};
                     dec_state = S_READ;
                  end
               end
               REQ_EXTENTS: begin
                  cmd.op = OP_EXT_CLEAR;
                  rsp_in.entry_index = count;
                  if (count != 7'd0) dec_state = S_SCAN;
               end
               REQ_PLACE: begin
                  if (count == 7'd0) rsp_in.status = STATUS_EMPTY;
                  else dec_state = S_PLACE;
               end
               default: dec_state = S_IDLE;
            endcase
         end
         S_SCAN:    cmd.op = OP_SCAN;
         S_REWRITE: cmd.op = OP_REWRITE;
         S_SHIFT: begin
            cmd.op = OP_SHIFT;
            if (!fv_ff && addr_ff >= count) count_dec = 1'b1;
         end
         S_EXT: begin
            rsp_in.min_x = mnx;
            rsp_in.min_y = mny;
            rsp_in.max_x = mxx;
            rsp_in.max_y = mxy;
         end
         S_READ: if (fv_ff) begin
            rsp_in.entry_index = addr_ff;
            rsp_in.out_x = 32'(signed'(rd_pos[15:0]));
            rsp_in.out_y = 32'(signed'(rd_pos[31:16]));
            rsp_in.out_type = rd_type;
            rsp_in.out_direction = rd_dir;
            rsp_in.out_metadata = rd_meta;
         end
         S_PLACE: if (!valid_ff && fv_ff) begin
            rsp_in.entry_index = addr_ff;
            rsp_in.out_x = req_ff.anchor_x + 32'(signed'(rd_pos[15:0]));
            rsp_in.out_y = req_ff.anchor_y + 32'(signed'(rd_pos[31:16]));
            rsp_in.out_type = rd_type;
            rsp_in.out_direction = rd_dir;
            rsp_in.out_metadata = rd_meta;
            rsp_in.last = (addr_ff[5:0] == last_idx);
         end
         default: begin end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         addr_ff  <= '0;
         fv_ff    <= 1'b0;
      end else begin
         rsp_ff <= rsp_in;
         if (valid_ff && rsp_ready) valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_valid && req_ready) begin
               req_ff   <= req_in;
               state_ff <= S_DECODE;
            end
            S_DECODE: begin
               fv_ff <= 1'b0;
               addr_ff <= dec_addr;
               state_ff <= dec_state;
            end
            S_SCAN: begin
               // The fetched entry arrives in the cycle after its address.
               fv_ff <= (addr_ff < count);
               if (addr_ff < count) addr_ff <= addr_ff + 7'd1;
               else if (!fv_ff || addr_ff == count) begin
                  if (!fv_ff) begin
                     addr_ff <= '0;
                     if (req_ff.req_type == REQ_EXTENTS) state_ff <= S_EXT;
                     else state_ff <= S_REWRITE;
                  end
               end
            end
            S_REWRITE: begin
               fv_ff <= (addr_ff < count);
               if (addr_ff < count) addr_ff <= addr_ff + 7'd1;
               else if (!fv_ff) state_ff <= S_SEND;
            end
            S_SHIFT: begin
               fv_ff <= (addr_ff < count);
               if (addr_ff < count) addr_ff <= addr_ff + 7'd1;
               else if (!fv_ff) state_ff <= S_SEND;
            end
            S_EXT: state_ff <= S_SEND;
            S_READ: begin
               if (fv_ff) begin
                  fv_ff <= 1'b0;
                  state_ff <= S_SEND;
               end else fv_ff <= 1'b1;
            end
            S_PLACE: if (!valid_ff) begin
               if (fv_ff) begin
                  valid_ff <= 1'b1;
                  fv_ff <= 1'b0;
                  if (addr_ff[5:0] == last_idx) state_ff <= S_IDLE;
                  else addr_ff <= addr_ff + 7'd1;
               end else fv_ff <= 1'b1;
            end
            S_SEND: if (!valid_ff) begin
               valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: rtl/tile_template_transform_table_core.sv
// Add, clear, read, error and empty-table requests each give one result; transforms other
// than a zero rotation scan and then rewrite every entry, and extents scan every entry.
// Remove shifts down the entries after the index. Place gives one result per entry, in order.
// One request at a time; the next is taken once the last result has been transferred.
// Reset is synchronous and active high; it empties the table and idles the controller.
module tile_template_transform_table_core import ttt_pkg::*; #(
   parameter int unsigned TABLE_SLOTS = MaxEntriesDefault
) (
   input logic clock,
   input logic reset,
   ttt_req_if.sink   req,
   ttt_rsp_if.source rsp
);

   // The table stores at most sixty-four entries whatever the parameter says.
   localparam int unsigned Cap = (TABLE_SLOTS < TableLimit) ? TABLE_SLOTS : TableLimit;

   dp_cmd_type    cmd;
   dp_status_type stat;
   req_type_type  req_ff;
   req_type_type  req_in;
   logic [31:0]   rd_pos, rd_meta;
   logic [15:0]   rd_type;
   logic [1:0]    rd_dir;
   logic signed [15:0] mnx, mny, mxx, mxy;
   logic          inc, dec, clr;

   always_comb begin
      req_in = req.payload;
   end

   // The controller refuses an add once the configured capacity is reached.
   ttt_controller #(
      .ENTRY_CAP (Cap)
   ) u_ctrl (
      .clock, .reset,
      .req_valid (req.valid),
      .req_ready (req.ready),
      .req_in    (req_in),
      .req_ff    (req_ff),
      .stat      (stat),
      .cmd       (cmd),
      .count_inc (inc),
      .count_dec (dec),
      .count_clr (clr),
      .rd_pos, .rd_type, .rd_dir, .rd_meta,
      .mnx, .mny, .mxx, .mxy,
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .rsp_ff    (rsp.payload)
   );

   ttt_datapath u_dp (
      .clock, .reset,
      .cmd, .req (req_ff), .stat,
      .rd_pos, .rd_type, .rd_dir, .rd_meta,
      .mnx_ff (mnx), .mny_ff (mny), .mxx_ff (mxx), .mxy_ff (mxy),
      .count_inc (inc), .count_dec (dec), .count_clr (clr)
   );

endmodule

FILE: rtl/ttt_checker.sv
module ttt_checker import ttt_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input rsp_type_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result dropped while stalled");

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last |-> !req_ready)
      else $error("request taken during place");

   a_ok_ext: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == STATUS_EMPTY |-> rsp_payload.last)
      else $error("empty status not final");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result after reset");

endmodule

bind tile_template_transform_table_core ttt_checker u_chk (
   .clock, .reset,
   .req_valid (req.valid), .req_ready (req.ready),
   .rsp_valid (rsp.valid), .rsp_ready (rsp.ready),
   .rsp_payload (rsp.payload)
);
